@@ rtl/crba_pkg.sv @@
// Shared types and constants for the cubic ramp burn amount block.
// Holds widths, register codes, reset values and the pipeline sideband type.
// No dependencies.
package crba_pkg;

    localparam int VW  = 64;
    localparam int HW  = VW / 2;
    localparam int PW  = 2 * VW;
    localparam int CIW = 2;

    localparam logic [VW-1:0] FLOOR_RST = '0;
    localparam logic [VW-1:0] CAP_RST   = VW'(64'd100000000000000000);
    localparam logic [VW-1:0] SCALE_RST = VW'(64'd100000000000);

    typedef enum logic [CIW-1:0] {
        REG_FLOOR = 2'd0,
        REG_CAP   = 2'd1,
        REG_SCALE = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        CLS_RAMP = 2'd0,
        CLS_ZERO = 2'd1,
        CLS_FULL = 2'd2
    } t_cls;

    typedef struct packed {
        logic          vld;
        t_cls          cls;
        logic [VW-1:0] num;
    } t_side;

endpackage

@@ rtl/crba_mul.sv @@
// Two-stage full-width multiplier built from four half-width partial products.
// Depends on crba_pkg.
module crba_mul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [crba_pkg::VW-1:0] i_a,
    input  logic [crba_pkg::VW-1:0] i_b,
    input  crba_pkg::t_side         i_side,
    output logic [crba_pkg::VW-1:0] o_hi,
    output logic [crba_pkg::VW-1:0] o_lo,
    output crba_pkg::t_side         o_side
);
    logic [crba_pkg::VW-1:0] r_ll, r_lh, r_hl, r_hh;
    logic [crba_pkg::PW-1:0] r_prod, n_prod;
    crba_pkg::t_side         r_side1, r_side2;

    always_ff @(posedge i_clk) begin
        r_ll <= i_a[crba_pkg::HW-1:0] * i_b[crba_pkg::HW-1:0];
        r_lh <= i_a[crba_pkg::HW-1:0] * i_b[crba_pkg::VW-1:crba_pkg::HW];
        r_hl <= i_a[crba_pkg::VW-1:crba_pkg::HW] * i_b[crba_pkg::HW-1:0];
        r_hh <= i_a[crba_pkg::VW-1:crba_pkg::HW] * i_b[crba_pkg::VW-1:crba_pkg::HW];
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_side1.vld <= 1'b0;
            r_side2.vld <= 1'b0;
        end else begin
            r_side1 <= i_side;
            r_side2 <= r_side1;
        end
    end

    always_comb begin
        n_prod = crba_pkg::PW'(r_ll)
               + (crba_pkg::PW'(r_lh) << crba_pkg::HW)
               + (crba_pkg::PW'(r_hl) << crba_pkg::HW)
               + (crba_pkg::PW'(r_hh) << crba_pkg::VW);
    end

    assign o_hi   = r_prod[crba_pkg::PW-1:crba_pkg::VW];
    assign o_lo   = r_prod[crba_pkg::VW-1:0];
    assign o_side = r_side2;
endmodule

@@ rtl/crba_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// The high word must be below the divisor. Depends on crba_pkg.
module crba_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [crba_pkg::VW-1:0] i_hi,
    input  logic [crba_pkg::VW-1:0] i_lo,
    input  logic [crba_pkg::VW-1:0] i_den,
    input  crba_pkg::t_side         i_side,
    output logic [crba_pkg::VW-1:0] o_quo,
    output crba_pkg::t_side         o_side
);
    logic [crba_pkg::VW-1:0] w_rem [0:crba_pkg::VW];
    logic [crba_pkg::VW-1:0] w_lo  [0:crba_pkg::VW];
    logic [crba_pkg::VW-1:0] w_quo [0:crba_pkg::VW];
    crba_pkg::t_side         w_sd  [0:crba_pkg::VW];

    assign w_rem[0] = i_hi;
    assign w_lo[0]  = i_lo;
    assign w_quo[0] = '0;
    assign w_sd[0]  = i_side;

    for (genvar k = 0; k < crba_pkg::VW; k++) begin : g_stage
        logic [crba_pkg::VW:0]   n_try;
        logic                    n_bit;
        logic [crba_pkg::VW-1:0] n_rem;
        logic [crba_pkg::VW-1:0] r_rem, r_lo, r_quo;
        crba_pkg::t_side         r_sd;

        always_comb begin
            n_try = {w_rem[k], w_lo[k][crba_pkg::VW-1]};
            n_bit = (n_try >= {1'b0, i_den});
            n_rem = n_bit ? crba_pkg::VW'(n_try - {1'b0, i_den})
                          : n_try[crba_pkg::VW-1:0];
        end

        always_ff @(posedge i_clk) begin
            r_rem <= n_rem;
            r_lo  <= {w_lo[k][crba_pkg::VW-2:0], 1'b0};
            r_quo <= {w_quo[k][crba_pkg::VW-2:0], n_bit};
            if (!i_rst_n) begin
                r_sd.vld <= 1'b0;
            end else begin
                r_sd <= w_sd[k];
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_lo[k+1]  = r_lo;
        assign w_quo[k+1] = r_quo;
        assign w_sd[k+1]  = r_sd;
    end

    assign o_quo  = w_quo[crba_pkg::VW];
    assign o_side = w_sd[crba_pkg::VW];
endmodule

@@ rtl/crba_muldiv.sv @@
// One truncating multiply-divide step: multiplier followed by the bit divider.
// Depends on crba_pkg, crba_mul and crba_div.
module crba_muldiv (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [crba_pkg::VW-1:0] i_a,
    input  logic [crba_pkg::VW-1:0] i_b,
    input  logic [crba_pkg::VW-1:0] i_den,
    input  crba_pkg::t_side         i_side,
    output logic [crba_pkg::VW-1:0] o_quo,
    output crba_pkg::t_side         o_side
);
    logic [crba_pkg::VW-1:0] w_hi, w_lo;
    crba_pkg::t_side         w_side;

    crba_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (i_a),
        .i_b     (i_b),
        .i_side  (i_side),
        .o_hi    (w_hi),
        .o_lo    (w_lo),
        .o_side  (w_side)
    );

    crba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hi    (w_hi),
        .i_lo    (w_lo),
        .i_den   (i_den),
        .i_side  (w_side),
        .o_quo   (o_quo),
        .o_side  (o_side)
    );
endmodule

@@ rtl/cubic_ramp_burn_amount.sv @@
// Top level of the cubic ramp burn amount pipeline with its register file.
// Depends on crba_pkg and crba_muldiv.
//
// Channel   Direction  Handshake             Payload
// request   in         start, busy           i_supply
// result    out        o_done (one cycle)    o_burn_amount
// config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// One request enters per cycle while busy is low; the result passes the input
// register, three multiply-divide steps with one quotient bit per stage and
// the output register. Reset is synchronous and clears the valid bits; busy is high
// during reset and in the first cycle after it. The receiver cannot stall the results.
module cubic_ramp_burn_amount (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [crba_pkg::VW-1:0]  i_supply,
    output logic                     o_done,
    output logic [crba_pkg::VW-1:0]  o_burn_amount,
    input  logic                     i_cfg_we,
    input  logic [crba_pkg::CIW-1:0] i_cfg_idx,
    input  logic [crba_pkg::VW-1:0]  i_cfg_data
);
    logic [crba_pkg::VW-1:0] r_floor, r_cap, r_scale, r_den;
    logic                    r_live;
    crba_pkg::t_side         r_side0, n_side0;
    logic [crba_pkg::VW-1:0] w_q1, w_q2, w_q3;
    crba_pkg::t_side         w_s1, w_s2, w_s3;
    logic                    r_done;
    logic [crba_pkg::VW-1:0] r_out, n_out;

    always_ff @(posedge i_clk) begin
        r_den <= r_cap - r_floor;
        if (!i_rst_n) begin
            r_floor <= crba_pkg::FLOOR_RST;
            r_cap   <= crba_pkg::CAP_RST;
            r_scale <= crba_pkg::SCALE_RST;
            r_live  <= 1'b0;
        end else begin
            r_live <= 1'b1;
            if (i_cfg_we) begin
                case (crba_pkg::t_reg'(i_cfg_idx))
                    crba_pkg::REG_FLOOR: r_floor <= i_cfg_data;
                    crba_pkg::REG_CAP:   r_cap   <= i_cfg_data;
                    crba_pkg::REG_SCALE: r_scale <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign busy = !r_live;

    always_comb begin
        n_side0.vld = start && !busy;
        n_side0.num = i_supply - r_floor;
        if (i_supply < r_floor) begin
            n_side0.cls = crba_pkg::CLS_ZERO;
        end else if (i_supply >= r_cap) begin
            n_side0.cls = crba_pkg::CLS_FULL;
        end else begin
            n_side0.cls = crba_pkg::CLS_RAMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side0.vld <= 1'b0;
        end else begin
            r_side0 <= n_side0;
        end
    end

    crba_muldiv u_md1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_a (r_side0.num), .i_b (r_side0.num), .i_den (r_den),
        .i_side (r_side0), .o_quo (w_q1), .o_side (w_s1)
    );

    crba_muldiv u_md2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_a (w_q1), .i_b (w_s1.num), .i_den (r_den),
        .i_side (w_s1), .o_quo (w_q2), .o_side (w_s2)
    );

    crba_muldiv u_md3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_a (w_q2), .i_b (r_scale), .i_den (r_den),
        .i_side (w_s2), .o_quo (w_q3), .o_side (w_s3)
    );

    always_comb begin
        case (w_s3.cls)
            crba_pkg::CLS_ZERO: n_out = '0;
            crba_pkg::CLS_FULL: n_out = '1;
            default:            n_out = w_q3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_s3.vld;
        end
    end

    assign o_done        = r_done;
    assign o_burn_amount = r_out;

`ifndef SYNTHESIS
    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("Result strobe right after reset.");

    a_busy_quiet: assert property (@(posedge i_clk)
        busy |-> !o_done)
        else $error("Result strobe while busy.");

    a_zero_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s3.vld && w_s3.cls == crba_pkg::CLS_ZERO) |=> (o_done && o_burn_amount == '0))
        else $error("Below-floor request did not give zero.");

    a_full_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s3.vld && w_s3.cls == crba_pkg::CLS_FULL) |=> (o_done && o_burn_amount == '1))
        else $error("Capped request did not saturate.");
`endif
endmodule
